@@ rtl/bpra_pkg.sv @@
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared types and constants for the bitmap page run allocator: operation
// codes, request and response beats, controller states and scan status.
// ----------------------------------------------------------------------------
package bpra_pkg;

    // run length register
    localparam int RUN_LEN_W = 7;
    localparam logic [RUN_LEN_W-1:0] RUN_LENGTH_RESET = 7'd3;

    // operation codes
    typedef enum logic [1:0] {
        KIND_MARK_USED = 2'd0,
        KIND_MARK_FREE = 2'd1,
        KIND_TEST      = 2'd2,
        KIND_FIND      = 2'd3
    } kind_t;

    // request beat
    typedef struct packed {
        kind_t      kind;
        logic [7:0] page_index;
    } req_t;

    // response beat
    typedef struct packed {
        logic       page_used;
        logic       found;
        logic [7:0] run_start;
    } rsp_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OP
    } state_t;

    // per-word scan status
    typedef struct packed {
        logic                 hit;
        logic                 from_carry;
        logic [RUN_LEN_W-1:0] next_carry;
    } scan_t;

endpackage

@@ rtl/bitmap_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// First-fit page allocator over a bitmap held in a single-port-read memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): one operation per beat; mark a
//   page used, mark it free, test a page, or find the lowest free run.
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one beat per request.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes run_length; always
//   ready, to be written only while no request is in flight.
// Sequence: a mark or test response is loaded after the memory read of
//   the addressed word, then modify/write or bit select. A find response
//   is loaded once the run is found or the last word is read, after at
//   most WORD_COUNT words: the scan reads one bitmap word per cycle from
//   the memory's single read port.
// Issue: the next request is taken in the cycle after a response is
//   loaded, and not while an operation is in progress.
// Reset: run_length returns to 3 and a clearing pass writes every word to
//   zero, during which req_ready stays low.
// Stall: the response sits in an output register; a new request is still
//   accepted, and the block holds its finished result until the register
//   drains.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator #(
    parameter int WORD_COUNT = 4,
    parameter int WORD_BITS  = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpra_pkg::RUN_LEN_W-1:0] cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  bpra_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output bpra_pkg::rsp_t                 rsp
);

    localparam int CW          = bpra_pkg::RUN_LEN_W;
    localparam int AW          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BW          = $clog2(WORD_BITS);
    localparam int TOTAL_PAGES = WORD_COUNT * WORD_BITS;
    localparam int PAGE_W      = $clog2(TOTAL_PAGES + 1);
    localparam int SW          = (PAGE_W > 8) ? PAGE_W : 8;
    localparam int RECIP       = (65536 + WORD_BITS - 1) / WORD_BITS;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);

    bpra_pkg::state_t state_reg, state_next;

    logic [CW-1:0]    run_length_reg;
    logic [AW-1:0]    clr_cnt_reg;
    bpra_pkg::kind_t  kind_reg;
    logic [7:0]       page_reg;
    logic [7:0]       word8_reg;
    logic             in_range_reg;
    logic [AW-1:0]    addr_reg;
    logic [CW-1:0]    carry_reg;
    logic             rsp_valid_reg;
    bpra_pkg::rsp_t   rsp_reg;

    logic             req_fire;
    logic [24:0]      req_prod;
    logic [7:0]       req_word8;
    logic [AW+7:0]    req_word_ext;
    logic [AW-1:0]    req_word;
    logic             req_in_range;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [15:0]      word_prod;
    logic [7:0]       bit_full;
    logic [BW-1:0]    bit_idx;
    logic [WORD_BITS-1:0] bit_mask;

    logic [CW-1:0]    need;
    bpra_pkg::scan_t  scan;
    logic [BW-1:0]    scan_off;
    logic [SW-1:0]    base_page;
    logic [SW-1:0]    start_page;

    logic             is_mark;
    logic             is_find;
    logic             scan_done;
    logic             op_done;
    logic             can_finish;
    bpra_pkg::rsp_t   result;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_length_reg <= bpra_pkg::RUN_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            run_length_reg <= cfg_data;
        end
    end

    assign need = (run_length_reg == '0) ? CW'(1) : run_length_reg;

    // request decode: word by reciprocal multiply, exact for 8-bit pages
    assign req_fire     = req_valid && req_ready;
    assign req_prod     = {17'd0, req.page_index} * 25'(RECIP);
    assign req_word8    = req_prod[23:16];
    assign req_word_ext = {{AW{1'b0}}, req_word8};
    assign req_word     = req_word_ext[AW-1:0];
    assign req_in_range = 32'(req.page_index) < 32'(TOTAL_PAGES);

    // bit within the addressed word
    assign word_prod = {8'd0, word8_reg} * 16'(WORD_BITS);
    assign bit_full  = page_reg - word_prod[7:0];
    assign bit_idx   = bit_full[BW-1:0];
    assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_idx;

    // word scan
    bpra_word_scan #(
        .WORD_BITS (WORD_BITS),
        .BW        (BW)
    ) u_scan (
        .used_bits (rd_data),
        .carry     (carry_reg),
        .need      (need),
        .status    (scan),
        .offset    (scan_off)
    );

    assign base_page  = SW'(addr_reg) * SW'(WORD_BITS);
    assign start_page = scan.from_carry ? (base_page - SW'(carry_reg))
                                        : (base_page + SW'(scan_off));

    // operation status
    assign is_mark    = (kind_reg == bpra_pkg::KIND_MARK_USED) ||
                        (kind_reg == bpra_pkg::KIND_MARK_FREE);
    assign is_find    = (kind_reg == bpra_pkg::KIND_FIND);
    assign scan_done  = scan.hit || (addr_reg == LAST_WORD);
    assign op_done    = !is_find || scan_done;
    assign can_finish = op_done && (!rsp_valid_reg || rsp_ready);

    // result of the current operation
    always_comb
    begin
        result.page_used = (kind_reg == bpra_pkg::KIND_TEST) && in_range_reg &&
                           rd_data[bit_idx];
        result.found     = is_find && scan.hit;
        result.run_start = (is_find && scan.hit) ? start_page[7:0] : 8'd0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpra_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = bpra_pkg::ST_IDLE;
                end
            end
            bpra_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = bpra_pkg::ST_OP;
                end
            end
            bpra_pkg::ST_OP:
            begin
                if (can_finish)
                begin
                    state_next = bpra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpra_pkg::ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake
    always_comb
    begin
        req_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = addr_reg;
        wr_en     = 1'b0;
        wr_addr   = addr_reg;
        wr_data   = (kind_reg == bpra_pkg::KIND_MARK_USED) ? (rd_data | bit_mask)
                                                           : (rd_data & ~bit_mask);
        case (state_reg)
            bpra_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            bpra_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                rd_en     = req_fire;
                rd_addr   = (req.kind == bpra_pkg::KIND_FIND) ? '0 : req_word;
            end
            bpra_pkg::ST_OP:
            begin
                if (is_find && !scan_done)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(addr_reg + 1'b1);
                end
                if (is_mark && in_range_reg && can_finish)
                begin
                    wr_en = 1'b1;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // bitmap memory
    bpra_map_mem #(
        .DEPTH (WORD_COUNT),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpra_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == bpra_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= AW'(clr_cnt_reg + 1'b1);
            end
            if ((state_reg == bpra_pkg::ST_OP) && can_finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // operation context and response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg     <= req.kind;
            page_reg     <= req.page_index;
            word8_reg    <= req_word8;
            in_range_reg <= req_in_range;
            addr_reg     <= (req.kind == bpra_pkg::KIND_FIND) ? '0 : req_word;
            carry_reg    <= '0;
        end
        else if ((state_reg == bpra_pkg::ST_OP) && is_find && !scan_done)
        begin
            addr_reg  <= AW'(addr_reg + 1'b1);
            carry_reg <= scan.next_carry;
        end
        if ((state_reg == bpra_pkg::ST_OP) && can_finish)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/bpra_map_mem.sv @@
// ----------------------------------------------------------------------------
// bpra_map_mem
// Page bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpra_map_mem #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 64,
    parameter int AW    = 2
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered, data held between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bpra_word_scan.sv @@
// ----------------------------------------------------------------------------
// bpra_word_scan
// Looks at one bitmap word for the lowest free run of the needed length,
// counting the free pages carried over from the words below it.
// ----------------------------------------------------------------------------
module bpra_word_scan #(
    parameter int WORD_BITS = 64,
    parameter int BW        = 6
) (
    input  logic [WORD_BITS-1:0]           used_bits,
    input  logic [bpra_pkg::RUN_LEN_W-1:0] carry,
    input  logic [bpra_pkg::RUN_LEN_W-1:0] need,
    output bpra_pkg::scan_t                status,
    output logic [BW-1:0]                  offset
);

    localparam int CW = bpra_pkg::RUN_LEN_W;

    logic [WORD_BITS-1:0]   free_bits;
    logic [2*WORD_BITS-1:0] free_ext;
    logic [WORD_BITS-1:0]   run_ok;
    logic [CW-1:0]          lead_lo;
    logic [CW-1:0]          lead_hi;
    logic                   a_hit;
    logic                   b_hit;
    logic [BW-1:0]          b_off;
    logic [CW:0]            carry_sum;
    logic                   fits;

    assign free_bits = ~used_bits;
    assign free_ext  = {{WORD_BITS{1'b0}}, free_bits};

    // a run longer than one word never lies wholly inside it
    assign fits = need <= CW'(WORD_BITS);

    // free pages at the bottom and at the top of the word
    always_comb
    begin
        lead_lo = CW'(WORD_BITS);
        lead_hi = CW'(WORD_BITS);
        for (int s = WORD_BITS - 1; s >= 0; s--)
        begin
            if (!free_bits[s])
            begin
                lead_lo = CW'(s);
            end
        end
        for (int s = 0; s < WORD_BITS; s++)
        begin
            if (!free_bits[s])
            begin
                lead_hi = CW'(WORD_BITS - 1 - s);
            end
        end
    end

    // runs that lie wholly inside the word, one check per start bit
    always_comb
    begin
        for (int s = 0; s < WORD_BITS; s++)
        begin
            run_ok[s] = fits;
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if ((CW'(j) < need) && !free_ext[s + j])
                begin
                    run_ok[s] = 1'b0;
                end
            end
        end
    end

    // lowest in-word run start
    always_comb
    begin
        b_hit = 1'b0;
        b_off = '0;
        for (int s = WORD_BITS - 1; s >= 0; s--)
        begin
            if (run_ok[s])
            begin
                b_hit = 1'b1;
                b_off = BW'(s);
            end
        end
    end

    // run continuing from lower words ends first when it completes here
    assign a_hit = ({1'b0, carry} + {1'b0, lead_lo}) >= {1'b0, need};

    // free pages ending at the top of this word, saturating
    assign carry_sum = {1'b0, carry} + (CW + 1)'(WORD_BITS);

    always_comb
    begin
        status.hit        = a_hit | b_hit;
        status.from_carry = a_hit;
        if (lead_lo == CW'(WORD_BITS))
        begin
            status.next_carry = carry_sum[CW] ? {CW{1'b1}} : carry_sum[CW-1:0];
        end
        else
        begin
            status.next_carry = lead_hi;
        end
    end

    assign offset = b_off;

endmodule

@@ tb/bitmap_page_run_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator_tb
// Self-checking bench for the first-fit page run allocator. A driver pushes
// request beats from a queue with random gaps, and a monitor takes response
// beats with random stalls. Each response is checked field by field against
// a bitmap model of the allocator. run_length is rewritten between phases,
// once the block has gone quiet.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_COUNT   = 4;
    localparam int WORD_BITS    = 64;
    localparam int TOTAL_PAGES  = WORD_COUNT * WORD_BITS;
    localparam int CLK_HALF     = 4;
    localparam int MAX_WAIT     = 13;
    localparam int DRAIN_CYCLES = 2 * WORD_COUNT + 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RLW          = bpra_pkg::RUN_LEN_W;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [RLW-1:0]       cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    bpra_pkg::req_t       req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    bpra_pkg::rsp_t       rsp;

    // allocator model state
    logic [TOTAL_PAGES-1:0] page_map_model = '0;
    logic [RLW-1:0]         run_len_model  = bpra_pkg::RUN_LENGTH_RESET;

    bpra_pkg::req_t pending_reqs[$];
    bpra_pkg::rsp_t expected_rsps[$];
    int unsigned reqs_queued = 0;
    int unsigned reqs_sent   = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned req_gap     = 0;
    int unsigned req_quiet   = 0;
    int unsigned rsp_stall   = 0;
    int unsigned rsp_quiet   = 0;

    bitmap_page_run_allocator #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // apply one request to the bitmap model and return its response
    function automatic bpra_pkg::rsp_t predict_alloc_result(bpra_pkg::req_t r);
        bpra_pkg::rsp_t res;
        int unsigned    need;
        int unsigned    free_run;
        res = '0;
        case (r.kind)
            bpra_pkg::KIND_MARK_USED, bpra_pkg::KIND_MARK_FREE:
            begin
                if (r.page_index < TOTAL_PAGES)
                    page_map_model[r.page_index] =
                        (r.kind == bpra_pkg::KIND_MARK_USED);
            end
            bpra_pkg::KIND_TEST:
            begin
                if (r.page_index < TOTAL_PAGES)
                    res.page_used = page_map_model[r.page_index];
            end
            default:
            begin
                // zero length behaves as a run of one
                need     = (run_len_model == 0) ? 1 : run_len_model;
                free_run = 0;
                for (int unsigned p = 0; p < TOTAL_PAGES; p++)
                begin
                    if (page_map_model[p])
                        free_run = 0;
                    else
                    begin
                        free_run++;
                        if (free_run == need)
                        begin
                            res.found     = 1'b1;
                            res.run_start = 8'(p + 1 - need);
                            break;
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic queue_op(bpra_pkg::kind_t k, logic [7:0] page);
        bpra_pkg::req_t r;
        r.kind       = k;
        r.page_index = page;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // block until every queued beat is sent and answered, then let it settle
    task automatic wait_drained();
        while (reqs_sent != reqs_queued || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_run_length(logic [RLW-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        run_len_model = value;
        cfg_valid     <= 1'b0;
    endtask

    // random traffic: mostly single ops, plus runs of marks (often across a
    // word boundary) each followed by a find
    task automatic queue_random_ops(int unsigned count);
        int unsigned     start;
        int unsigned     pick;
        int unsigned     lo;
        int unsigned     len;
        int unsigned     page;
        bpra_pkg::kind_t k;
        start = reqs_queued;
        while (reqs_queued - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 14)
            begin
                len = (pick < 4) ? $urandom_range(1, 130) : $urandom_range(1, 20);
                if ($urandom_range(0, 1) == 0)
                    lo = $urandom_range(0, TOTAL_PAGES - 1);
                else
                    lo = WORD_BITS * $urandom_range(1, WORD_COUNT - 1) - $urandom_range(0, 40);
                k = ($urandom_range(0, 2) == 0) ? bpra_pkg::KIND_MARK_USED
                                                : bpra_pkg::KIND_MARK_FREE;
                for (int unsigned p = lo; p < lo + len && p < TOTAL_PAGES; p++)
                    queue_op(k, 8'(p));
                queue_op(bpra_pkg::KIND_FIND, 8'($urandom_range(0, 255)));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    k = bpra_pkg::KIND_MARK_USED;
                else if (pick < 50)
                    k = bpra_pkg::KIND_MARK_FREE;
                else if (pick < 75)
                    k = bpra_pkg::KIND_TEST;
                else
                    k = bpra_pkg::KIND_FIND;
                // word edges get extra weight
                if ($urandom_range(0, 4) == 0)
                    page = WORD_BITS * $urandom_range(0, WORD_COUNT - 1)
                         + (($urandom_range(0, 1) == 0) ? 0 : WORD_BITS - 1);
                else
                    page = $urandom_range(0, 255);
                queue_op(k, 8'(page));
            end
        end
    endtask

    task automatic run_phase(logic [RLW-1:0] run_len, int unsigned count,
                             bit pause_midway);
        write_run_length(run_len);
        if (pause_midway)
        begin
            queue_random_ops(count / 2);
            wait_drained();
            queue_random_ops(count - count / 2);
        end
        else
            queue_random_ops(count);
        wait_drained();
    endtask

    // request driver: one beat per pending entry, random gap per beat
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        int unsigned gap;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_gap   <= 0;
            req_quiet <= 0;
        end
        else
        begin
            gap = req_gap;
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(predict_alloc_result(req));
                reqs_sent++;
                if (req_quiet != 0)
                begin
                    gap = 0;
                    req_quiet <= req_quiet - 1;
                end
                else if ($urandom_range(0, 24) == 0)
                begin
                    gap = 0;
                    req_quiet <= $urandom_range(8, 40);
                end
                else
                    gap = $urandom_range(0, MAX_WAIT);
            end
            // a beat not yet taken is held as is
            if (!req_valid || req_ready)
            begin
                if (gap != 0)
                begin
                    req_valid <= 1'b0;
                    req_gap   <= gap - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_gap   <= 0;
                end
                else
                begin
                    req_valid <= 1'b0;
                    req_gap   <= 0;
                end
            end
        end
    end

    // response monitor: checks each beat, then stalls a random number of cycles
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        int unsigned    stall;
        bpra_pkg::rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_stall <= 0;
            rsp_quiet <= 0;
        end
        else
        begin
            stall = rsp_stall;
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    error_count++;
                    $display("%0t: response expected none actual %p", $time, rsp);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.page_used !== want.page_used)
                    begin
                        error_count++;
                        $display("%0t: page_used expected %0b actual %0b",
                                 $time, want.page_used, rsp.page_used);
                    end
                    if (rsp.found !== want.found)
                    begin
                        error_count++;
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, rsp.found);
                    end
                    if (rsp.run_start !== want.run_start)
                    begin
                        error_count++;
                        $display("%0t: run_start expected %0d actual %0d",
                                 $time, want.run_start, rsp.run_start);
                    end
                end
                if (rsp_quiet != 0)
                begin
                    stall = 0;
                    rsp_quiet <= rsp_quiet - 1;
                end
                else if ($urandom_range(0, 24) == 0)
                begin
                    stall = 0;
                    rsp_quiet <= $urandom_range(8, 40);
                end
                else
                    stall = $urandom_range(0, MAX_WAIT);
            end
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                rsp_stall <= stall - 1;
            end
            else
            begin
                rsp_ready <= 1'b1;
                rsp_stall <= 0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // reset, directed checks, then random phases over several run lengths
    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty map, word edges and the map ends, at the reset run length
        queue_op(bpra_pkg::KIND_FIND, 8'd255);
        queue_op(bpra_pkg::KIND_TEST, 8'd0);
        queue_op(bpra_pkg::KIND_TEST, 8'd255);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd0);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd63);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd64);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd127);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd128);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd191);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd192);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd255);
        queue_op(bpra_pkg::KIND_TEST, 8'd63);
        queue_op(bpra_pkg::KIND_TEST, 8'd64);
        queue_op(bpra_pkg::KIND_TEST, 8'd255);
        queue_op(bpra_pkg::KIND_FIND, 8'd0);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd2);
        queue_op(bpra_pkg::KIND_FIND, 8'd0);
        queue_op(bpra_pkg::KIND_MARK_USED, 8'd5);
        queue_op(bpra_pkg::KIND_FIND, 8'd0);
        queue_op(bpra_pkg::KIND_MARK_FREE, 8'd0);
        queue_op(bpra_pkg::KIND_MARK_FREE, 8'd255);
        queue_op(bpra_pkg::KIND_TEST, 8'd0);
        queue_op(bpra_pkg::KIND_TEST, 8'd255);
        queue_op(bpra_pkg::KIND_FIND, 8'd170);
        wait_drained();

        // zero length, shortest, one word, longest, and a few in between
        run_phase(7'd0, 100, 1'b0);
        run_phase(7'd1, 100, 1'b0);
        run_phase(7'd64, 100, 1'b1);
        run_phase(7'd127, 100, 1'b0);
        run_phase(7'd2, 100, 1'b0);
        run_phase(7'd65, 100, 1'b0);
        run_phase(bpra_pkg::RUN_LENGTH_RESET, 100, 1'b0);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
